[sv/txesc_pkg.sv]
// Shared types, constants and functions of the text escape encoder.
// Depends on nothing; every module of the encoder imports it.
`default_nettype none

package txesc_pkg;

	// Escape schemes held by the mode register.
	localparam logic [1:0] MODE_URL  = 2'd0;
	localparam logic [1:0] MODE_XML  = 2'd1;
	localparam logic [1:0] MODE_JSON = 2'd2;

	// Kinds of escaped sequence that the front part assigns to a byte.
	localparam logic [2:0] KIND_PASS = 3'd0;   // the byte itself
	localparam logic [2:0] KIND_PCT  = 3'd1;   // %hh
	localparam logic [2:0] KIND_AMP  = 3'd2;   // &amp;
	localparam logic [2:0] KIND_LT   = 3'd3;   // &lt;
	localparam logic [2:0] KIND_BSL  = 3'd4;   // backslash and one letter
	localparam logic [2:0] KIND_UNI  = 3'd5;   // \u00hh

	// ASCII characters used in the sequences.
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SEMI    = 8'h3b;
	localparam logic [7:0] CH_LT      = 8'h3c;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_A       = 8'h61;
	localparam logic [7:0] CH_B       = 8'h62;
	localparam logic [7:0] CH_F       = 8'h66;
	localparam logic [7:0] CH_L       = 8'h6c;
	localparam logic [7:0] CH_M       = 8'h6d;
	localparam logic [7:0] CH_N       = 8'h6e;
	localparam logic [7:0] CH_P       = 8'h70;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_U       = 8'h75;

	typedef logic [2:0] kind_t;
	typedef logic [2:0] step_t;

	// One classified word as it travels from the front part to the back part.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] arg;
		logic       eot;
	} entry_t;

	// Lower-case hex digit for one nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

	// Index of the final byte of a sequence of the given kind.
	function automatic step_t last_step(input kind_t kind);
		step_t r;
		unique case (kind)
			KIND_PASS: r = 3'd0;
			KIND_PCT:  r = 3'd2;
			KIND_AMP:  r = 3'd4;
			KIND_LT:   r = 3'd3;
			KIND_BSL:  r = 3'd1;
			KIND_UNI:  r = 3'd5;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

	// Byte number step of the sequence of the given kind.
	function automatic logic [7:0] seq_byte(input kind_t kind, input logic [7:0] arg,
			input step_t step);
		logic [7:0] r;
		r = arg;
		unique case (kind)
			KIND_PCT: begin
				unique case (step)
					3'd0:    r = CH_PERCENT;
					3'd1:    r = hex_digit(arg[7:4]);
					default: r = hex_digit(arg[3:0]);
				endcase
			end
			KIND_AMP: begin
				unique case (step)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_A;
					3'd2:    r = CH_M;
					3'd3:    r = CH_P;
					default: r = CH_SEMI;
				endcase
			end
			KIND_LT: begin
				unique case (step)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_L;
					3'd2:    r = CH_T;
					default: r = CH_SEMI;
				endcase
			end
			KIND_BSL: begin
				r = (step == 3'd0) ? CH_BSLASH : arg;
			end
			KIND_UNI: begin
				unique case (step)
					3'd0:    r = CH_BSLASH;
					3'd1:    r = CH_U;
					3'd2:    r = CH_ZERO;
					3'd3:    r = CH_ZERO;
					3'd4:    r = hex_digit(arg[7:4]);
					default: r = hex_digit(arg[3:0]);
				endcase
			end
			default: r = arg;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/text_escape_encoder.sv]
// Top level of the text escape encoder: mode register, front, queue and back.
// Depends on txesc_pkg, txesc_classify, txesc_queue and txesc_emit.
`default_nettype none

// The encoder escapes a byte stream for URL, XML or JSON use (the spare mode
// passes bytes through), as chosen by escape_mode (write only while idle).
// Each input word is classified on entry and queued; the back part sends one
// output word per cycle while pop is held, and an input byte yields 1 to 6 output
// words depending on its escape sequence. Input words are taken one per cycle
// while the QUEUE_DEPTH-entry queue has room; sustained throughput is set by the
// single output port at one output byte per cycle while pop is held. An input word
// passes through the queue and the output register before its first output word shows.

module text_escape_encoder
	import txesc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       escape_mode_we,
	input  wire logic [1:0] escape_mode,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            end_out
);

	logic [1:0] mode_q;
	entry_t in_entry;
	entry_t head;
	logic head_valid;
	logic head_pop;
	logic push_ok;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_URL;
		end else if (escape_mode_we) begin
			mode_q <= escape_mode;
		end
	end

	assign push_ok = push && !full;

	// Front part classifies the incoming word.
	txesc_classify u_classify (
		.escape_mode (mode_q),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.entry       (in_entry)
	);

	// Queue between front and back.
	txesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push_ok),
		.wr_entry (in_entry),
		.full     (full),
		.rd_en    (head_pop),
		.rd_entry (head),
		.rd_valid (head_valid)
	);

	// Back part emits the sequence bytes.
	txesc_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.head_pop    (head_pop),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.end_out     (end_out)
	);

endmodule

`default_nettype wire

[sv/txesc_classify.sv]
// Front part of the text escape encoder: sorts each raw byte into a sequence kind.
// Depends on txesc_pkg.
`default_nettype none

module txesc_classify
	import txesc_pkg::*;
(
	input  wire logic [1:0] escape_mode,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output entry_t          entry
);

	logic unreserved;
	kind_t kind;
	logic [7:0] arg;

	// Characters that URL encoding leaves alone.
	assign unreserved = (in_byte >= 8'h41 && in_byte <= 8'h5a)
		|| (in_byte >= 8'h61 && in_byte <= 8'h7a)
		|| (in_byte >= 8'h30 && in_byte <= 8'h39)
		|| in_byte == 8'h2d || in_byte == 8'h5f || in_byte == 8'h2e || in_byte == 8'h7e;

	// Pick the sequence kind and the byte that parameterizes it.
	always_comb begin
		kind = KIND_PASS;
		arg  = in_byte;
		unique case (escape_mode)
			MODE_URL: begin
				kind = unreserved ? KIND_PASS : KIND_PCT;
			end
			MODE_XML: begin
				if (in_byte == CH_AMP) begin
					kind = KIND_AMP;
				end else if (in_byte == CH_LT) begin
					kind = KIND_LT;
				end
			end
			MODE_JSON: begin
				priority if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
					kind = KIND_BSL;
				end else if (in_byte == 8'h08) begin
					kind = KIND_BSL;
					arg  = CH_B;
				end else if (in_byte == 8'h09) begin
					kind = KIND_BSL;
					arg  = CH_T;
				end else if (in_byte == 8'h0c) begin
					kind = KIND_BSL;
					arg  = CH_F;
				end else if (in_byte == 8'h0a) begin
					kind = KIND_BSL;
					arg  = CH_N;
				end else if (in_byte == 8'h0d) begin
					kind = KIND_BSL;
					arg  = CH_R;
				end else if (in_byte <= 8'h1f) begin
					kind = KIND_UNI;
				end else begin
					kind = KIND_PASS;
				end
			end
			default: begin
				kind = KIND_PASS;
			end
		endcase
	end

	assign entry = '{kind: kind, arg: arg, eot: end_of_text};

endmodule

`default_nettype wire

[sv/txesc_queue.sv]
// Short queue of classified words between the front and back parts.
// Depends on txesc_pkg for the word type.
`default_nettype none

module txesc_queue
	import txesc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire entry_t wr_entry,
	output logic        full,
	input  wire logic   rd_en,
	output entry_t      rd_entry,
	output logic        rd_valid
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	// Storage of the words.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/txesc_emit.sv]
// Back part of the text escape encoder: steps through each sequence a byte a cycle while pop drains it.
// Depends on txesc_pkg for the word type and the sequence functions.
`default_nettype none

module txesc_emit
	import txesc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire entry_t     head,
	input  wire logic       head_valid,
	output logic            head_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            end_out
);

	step_t step_q;
	logic out_valid_q;
	logic [7:0] byte_q;
	logic last_q;
	logic end_q;
	logic load;
	logic at_last;

	// The output register takes a new word when it is empty or being drained.
	assign load     = head_valid && (!out_valid_q || pop);
	assign at_last  = (step_q == last_step(head.kind));
	assign head_pop = load && at_last;

	// Step counter within the current sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= at_last ? '0 : step_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= seq_byte(head.kind, head.arg, step_q);
			last_q <= at_last;
			end_q  <= at_last && head.eot;
		end
	end

	assign empty       = !out_valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;
	assign end_out     = end_q;

endmodule

`default_nettype wire

[dv/text_escape_encoder_tb.sv]
// Self-checking testbench for text_escape_encoder: directed and random words in
// every escape mode, with random idling on both queue sides.
// Depends on txesc_pkg and the text_escape_encoder RTL.
`timescale 1ns / 1ps

module text_escape_encoder_tb;
	import txesc_pkg::*;

	// The mode value that the block treats as plain pass-through.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Control bytes with a short JSON escape, and the top of the control range.
	localparam logic [7:0] ASC_BS  = 8'h08;
	localparam logic [7:0] ASC_TAB = 8'h09;
	localparam logic [7:0] ASC_LF  = 8'h0a;
	localparam logic [7:0] ASC_FF  = 8'h0c;
	localparam logic [7:0] ASC_CR  = 8'h0d;
	localparam logic [7:0] ASC_US  = 8'h1f;

	// Idle styles of a queue side.
	localparam int IDLE_NONE  = 0;
	localparam int IDLE_WIDE  = 1;
	localparam int IDLE_SPARSE = 2;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_WORDS  = 52;
	localparam int PHASE_COUNT  = 8;

	// One escaped output word as the block should deliver it.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       end_out;
	} escaped_byte_t;

	// Escape predictor and the queue of output words still owed by the block.
	class escape_scoreboard;
		logic [1:0]    mode;
		escaped_byte_t owed[$];
		int            fault_count;

		function new();
			mode = MODE_URL;
			fault_count = 0;
		endfunction

		function void set_mode(input logic [1:0] m);
			mode = m;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function logic [7:0] hex_char(input logic [3:0] nib);
			string digits;
			digits = "0123456789abcdef";
			return digits[nib];
		endfunction

		// Work out the escaped sequence of one accepted input word.
		function void note_word(input logic [7:0] b, input logic eot);
			logic [7:0]    seq[$];
			logic [7:0]    letter;
			escaped_byte_t e;
			seq = {};
			case (mode)
				MODE_URL: begin
					if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
							(b >= "0" && b <= "9") || b == "-" || b == "_" ||
							b == "." || b == "~") begin
						seq.push_back(b);
					end else begin
						seq.push_back(CH_PERCENT);
						seq.push_back(hex_char(b[7:4]));
						seq.push_back(hex_char(b[3:0]));
					end
				end
				MODE_XML: begin
					if (b == CH_AMP) begin
						seq.push_back(CH_AMP);
						seq.push_back(CH_A);
						seq.push_back(CH_M);
						seq.push_back(CH_P);
						seq.push_back(CH_SEMI);
					end else if (b == CH_LT) begin
						seq.push_back(CH_AMP);
						seq.push_back(CH_L);
						seq.push_back(CH_T);
						seq.push_back(CH_SEMI);
					end else begin
						seq.push_back(b);
					end
				end
				MODE_JSON: begin
					case (b)
						CH_QUOTE:  letter = CH_QUOTE;
						CH_BSLASH: letter = CH_BSLASH;
						ASC_BS:    letter = CH_B;
						ASC_TAB:   letter = CH_T;
						ASC_FF:    letter = CH_F;
						ASC_LF:    letter = CH_N;
						ASC_CR:    letter = CH_R;
						default:   letter = 8'h00;
					endcase
					if (letter != 8'h00) begin
						seq.push_back(CH_BSLASH);
						seq.push_back(letter);
					end else if (b <= ASC_US) begin
						seq.push_back(CH_BSLASH);
						seq.push_back(CH_U);
						seq.push_back(CH_ZERO);
						seq.push_back(CH_ZERO);
						seq.push_back(hex_char(b[7:4]));
						seq.push_back(hex_char(b[3:0]));
					end else begin
						seq.push_back(b);
					end
				end
				default: begin
					seq.push_back(b);
				end
			endcase
			foreach (seq[k]) begin
				e.out_byte = seq[k];
				e.last_of_run = (k == seq.size() - 1);
				e.end_out = e.last_of_run & eot;
				owed.push_back(e);
			end
		endfunction

		// Compare one accepted output word with the oldest owed word.
		function void check_word(input logic [7:0] ob, input logic lr, input logic eo);
			escaped_byte_t want;
			if (owed.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected output word: byte %h last %b end %b", ob, lr, eo);
				return;
			end
			want = owed.pop_front();
			if (ob !== want.out_byte || lr !== want.last_of_run || eo !== want.end_out) begin
				fault_count++;
				if (fault_count <= 10)
					$display("output word mismatch: expected byte %h last %b end %b, got byte %h last %b end %b",
						want.out_byte, want.last_of_run, want.end_out, ob, lr, eo);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       escape_mode_we;
	logic [1:0] escape_mode;
	logic       push;
	logic       full;
	logic [7:0] in_byte;
	logic       end_of_text;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       end_out;

	escape_scoreboard board;
	int cycles;
	int in_style;
	int out_style;

	text_escape_encoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.escape_mode_we (escape_mode_we),
		.escape_mode    (escape_mode),
		.push           (push),
		.full           (full),
		.in_byte        (in_byte),
		.end_of_text    (end_of_text),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.end_out        (end_out)
	);

	always #1 clk = ~clk;

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** text_escape_encoder: FAILED **");
			$finish;
		end
	end

	// Number of idle cycles before the next word on one side.
	function automatic int draw_gap(input int style);
		case (style)
			IDLE_NONE: return 0;
			IDLE_WIDE: return int'($urandom_range(0, 18));
			default:   return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
		endcase
	endfunction

	// Random text byte, biased toward bytes that each mode escapes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: begin
				case ($urandom_range(0, 11))
					0:  return CH_AMP;
					1:  return CH_LT;
					2:  return CH_QUOTE;
					3:  return CH_BSLASH;
					4:  return "-";
					5:  return "_";
					6:  return ".";
					7:  return "~";
					8:  return CH_PERCENT;
					9:  return 8'h7f;
					10: return 8'hff;
					default: return 8'h00;
				endcase
			end
			2: return 8'($urandom_range(0, 31));
			default: return 8'($urandom_range(8'h20, 8'h7e));
		endcase
	endfunction

	// Offer one input word and wait until the block takes it.
	task automatic send_word(input logic [7:0] b, input logic eot);
		int gap;
		gap = draw_gap(in_style);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (full !== 1'b0) @(posedge clk);
		board.note_word(b, eot);
	endtask

	// Drain the block, then write the mode register.
	task automatic set_mode(input logic [1:0] m);
		push <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		escape_mode_we <= 1'b1;
		escape_mode <= m;
		@(posedge clk);
		escape_mode_we <= 1'b0;
		board.set_mode(m);
	endtask

	// Output side: pop words with random stalls and check each one.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(out_style);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty !== 1'b0) @(posedge clk);
			board.check_word(out_byte, last_of_run, end_out);
		end
	end

	// Input side: reset, directed words per mode, then random texts.
	initial begin
		logic [7:0] url_set [8];
		logic [7:0] xml_set [4];
		logic [7:0] json_set [11];
		logic [1:0] phase_mode [PHASE_COUNT];
		int         words;
		int         len;
		logic       eot;

		url_set = '{8'h00, 8'hff, "A", "z", "9", "-", "~", " "};
		xml_set = '{CH_AMP, CH_LT, 8'h00, 8'h80};
		json_set = '{CH_QUOTE, CH_BSLASH, ASC_BS, ASC_TAB, ASC_FF, ASC_LF, ASC_CR,
			8'h00, ASC_US, 8'h7f, 8'hff};
		phase_mode = '{MODE_JSON, MODE_URL, MODE_SPARE, MODE_XML, MODE_URL, MODE_JSON,
			MODE_XML, MODE_SPARE};

		clk = 1'b0;
		arst_n = 1'b0;
		escape_mode_we = 1'b0;
		escape_mode = MODE_URL;
		push = 1'b0;
		in_byte = 8'h00;
		end_of_text = 1'b0;
		pop = 1'b0;
		cycles = 0;
		in_style = IDLE_NONE;
		out_style = IDLE_NONE;
		board = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words, URL mode straight out of reset.
		foreach (url_set[k]) send_word(url_set[k], k == 7);

		in_style = IDLE_WIDE;
		set_mode(MODE_XML);
		foreach (xml_set[k]) send_word(xml_set[k], k == 3);

		in_style = IDLE_NONE;
		out_style = IDLE_WIDE;
		set_mode(MODE_JSON);
		foreach (json_set[k]) send_word(json_set[k], k == 10 || k == 4);

		out_style = IDLE_SPARSE;
		set_mode(MODE_SPARE);
		send_word(CH_AMP, 1'b0);
		send_word(8'h00, 1'b1);

		// Random texts, one phase per mode setting and idle style.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin in_style = IDLE_NONE; out_style = IDLE_NONE; end
				1: begin in_style = IDLE_WIDE; out_style = IDLE_NONE; end
				2: begin in_style = IDLE_NONE; out_style = IDLE_WIDE; end
				default: begin
					in_style = int'($urandom_range(0, 2));
					out_style = int'($urandom_range(0, 2));
				end
			endcase
			set_mode(phase_mode[p]);
			words = 0;
			while (words < PHASE_WORDS) begin
				len = int'($urandom_range(1, 12));
				for (int k = 0; k < len; k++) begin
					eot = (k == len - 1);
					// Now and then a stray end marker in mid-text.
					if ($urandom_range(0, 9) == 0)
						eot = 1'($urandom_range(0, 1));
					send_word(pick_byte(), eot);
					words++;
				end
			end
		end

		// Let every owed word come out, then a few quiet cycles.
		push <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (board.fault_count == 0 && board.pending() == 0) begin
			$display("** text_escape_encoder: PASSED **");
		end else begin
			$display("** text_escape_encoder: FAILED **");
		end
		$finish;
	end

endmodule
